// ===== hw/rtl/cspm_pkg.sv =====
// shared constants and sequencer state type for the cyclic shift point matcher
package cspm_pkg;

  localparam int POINTS_DEF = 4;   // corners per frame
  localparam int COORD_W    = 12;  // pixel coordinate width
  localparam int LABEL_W    = 2;   // width of label and shift fields

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM,
    ST_OFS,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_RSTART,
    ST_RWAIT,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } cspm_state_t;

endpackage

// ===== hw/rtl/cspm_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle, truncated result
module cspm_isqrt #(
  parameter int RAD_W  = 32,
  parameter int ROOT_W = RAD_W / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W  = ROOT_W + 3;
  localparam int ITER_W = $clog2(ROOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(ROOT_W);
      end else if (busy_r) begin
        iter_r <= iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rad_r  <= rad_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign root_o = root_r;

  // a new operand only arrives once the previous root is finished
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("isqrt started while busy");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (iter_r != '0))
    else $error("isqrt busy with no iterations left");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("isqrt done without a finished run");

endmodule

// ===== hw/rtl/cyclic_shift_point_matcher.sv =====
// top level of the cyclic shift point matcher: corner store, sequencer, result port
//
// Corners of one frame come in one transfer per cycle; the corner flagged
// in_last_corner closes the frame. Up to POINTS corners are kept, later ones are
// dropped, and corners that never arrived count as (0,0). Each corner's offset
// from the frame mean is kept exactly, scaled by POINTS. For every cyclic shift s
// the block sums the truncated Euclidean distances between new offset j and the
// previous frame's offset (j+s) mod POINTS, picks the shift with the smallest
// sum (the lower shift on a tie; shift 0 on the first frame after reset) and
// then sends POINTS results in input order, each with label (index + shift) mod
// POINTS. Every corner pair goes through one shared squaring multiplier and one
// iterative square root unit that settles two radicand bits per cycle, and that
// root unit sets the pace. While a frame is being worked on or its results are
// delivered, in_ready stays low.
module cyclic_shift_point_matcher #(
  parameter int POINTS = cspm_pkg::POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // corner input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cspm_pkg::COORD_W-1:0] in_corner_x,
  input  logic [cspm_pkg::COORD_W-1:0] in_corner_y,
  input  logic                         in_last_corner,
  // labelled corner output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cspm_pkg::LABEL_W-1:0] out_point_label,
  output logic [cspm_pkg::COORD_W-1:0] out_point_x,
  output logic [cspm_pkg::COORD_W-1:0] out_point_y,
  output logic [cspm_pkg::LABEL_W-1:0] out_chosen_shift,
  output logic                         out_last_point
);

  localparam int CW     = cspm_pkg::COORD_W;
  localparam int LW     = cspm_pkg::LABEL_W;
  localparam int IDX_W  = $clog2(POINTS);
  localparam int CNT_W  = $clog2(POINTS + 1);
  localparam int SUM_W  = CW + $clog2(POINTS);      // coordinate sum
  localparam int OFF_W  = SUM_W + 1;                // signed scaled offset
  localparam int SQ_W   = 2 * OFF_W + 1;            // dx*dx + dy*dy
  localparam int RAD_W  = 2 * OFF_W + 2;            // radicand, even width
  localparam int ROOT_W = OFF_W + 1;
  localparam int DSUM_W = ROOT_W + $clog2(POINTS);  // distance sum per shift

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  cspm_pkg::cspm_state_t state_r, state_nxt;

  // corner store, entries at or beyond the fill count read as zero
  logic [CW-1:0]    corner_x_r [POINTS];
  logic [CW-1:0]    corner_y_r [POINTS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             corner_we;

  // previous frame's offsets
  logic [OFF_W-1:0] prev_x_r [POINTS];
  logic [OFF_W-1:0] prev_y_r [POINTS];
  logic             prev_we;

  // sequencer datapath
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  s_r, s_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [DSUM_W-1:0] best_sum_r, best_sum_nxt;
  logic [DSUM_W-1:0] dsum_r, dsum_nxt;
  logic [SUM_W-1:0]  sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0]  sum_y_r, sum_y_nxt;
  logic [OFF_W-1:0]  nx_r, nx_nxt;
  logic [OFF_W-1:0]  ny_r, ny_nxt;
  logic [OFF_W-1:0]  dx_r, dx_nxt;
  logic [OFF_W-1:0]  dy_r, dy_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_label_r, out_label_nxt;
  logic [CW-1:0] out_x_r, out_x_nxt;
  logic [CW-1:0] out_y_r, out_y_nxt;
  logic [LW-1:0] out_shift_r, out_shift_nxt;
  logic          out_last_r, out_last_nxt;

  // combinational helpers
  logic [CW-1:0]        rd_x, rd_y;
  logic [SUM_W-1:0]     scaled_x, scaled_y;
  logic [OFF_W-1:0]     off_x, off_y;
  logic [IDX_W:0]       k_sum, lbl_sum;
  logic [IDX_W-1:0]     k_idx, lbl_idx;
  logic [OFF_W:0]       dxw, dyw;
  logic [OFF_W-1:0]     mul_a;
  logic [2*OFF_W-1:0]   prod;
  logic [DSUM_W-1:0]    dsum_tot;
  logic                 sq_start;
  logic                 sq_busy;
  logic                 sq_done;
  logic [ROOT_W-1:0]    sq_root;

  // corner read at the sequencer index, padded with zero past the fill count
  assign rd_x = (CNT_W'(j_r) < cnt_r) ? corner_x_r[j_r] : '0;
  assign rd_y = (CNT_W'(j_r) < cnt_r) ? corner_y_r[j_r] : '0;

  // offset from frame mean, scaled by POINTS so it stays exact
  assign scaled_x = SUM_W'(rd_x) * SUM_W'(POINTS);
  assign scaled_y = SUM_W'(rd_y) * SUM_W'(POINTS);
  assign off_x    = {1'b0, scaled_x} - {1'b0, sum_x_r};
  assign off_y    = {1'b0, scaled_y} - {1'b0, sum_y_r};

  // partner index (j + s) mod POINTS and label (j + best) mod POINTS
  assign k_sum   = {1'b0, j_r} + {1'b0, s_r};
  assign k_idx   = (k_sum >= (IDX_W+1)'(POINTS)) ? IDX_W'(k_sum - (IDX_W+1)'(POINTS))
                                                 : IDX_W'(k_sum);
  assign lbl_sum = {1'b0, j_r} + {1'b0, best_r};
  assign lbl_idx = (lbl_sum >= (IDX_W+1)'(POINTS)) ? IDX_W'(lbl_sum - (IDX_W+1)'(POINTS))
                                                   : IDX_W'(lbl_sum);

  // sign-extended differences against the stored partner offset
  assign dxw = {nx_r[OFF_W-1], nx_r} - {prev_x_r[k_idx][OFF_W-1], prev_x_r[k_idx]};
  assign dyw = {ny_r[OFF_W-1], ny_r} - {prev_y_r[k_idx][OFF_W-1], prev_y_r[k_idx]};

  // one shared squaring multiplier, x then y
  assign mul_a = (state_r == cspm_pkg::ST_SQX) ? dx_r : dy_r;
  assign prod  = (2*OFF_W)'(mul_a) * (2*OFF_W)'(mul_a);

  assign dsum_tot = dsum_r + DSUM_W'(sq_root);

  cspm_isqrt #(
    .RAD_W  (RAD_W),
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sq_start),
    .rad_i   (RAD_W'(sq_r)),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    s_nxt         = s_r;
    best_nxt      = best_r;
    best_sum_nxt  = best_sum_r;
    dsum_nxt      = dsum_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r;
    out_label_nxt = out_label_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_shift_nxt = out_shift_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;
    corner_we     = 1'b0;
    prev_we       = 1'b0;
    sq_start      = 1'b0;

    unique case (state_r)
      cspm_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // extra corners past POINTS are dropped but may still close the frame
          if (cnt_r < CNT_W'(POINTS)) begin
            corner_we = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (in_last_corner) begin
            j_nxt     = '0;
            sum_x_nxt = '0;
            sum_y_nxt = '0;
            state_nxt = cspm_pkg::ST_SUM;
          end
        end
      end

      cspm_pkg::ST_SUM: begin
        sum_x_nxt = sum_x_r + SUM_W'(rd_x);
        sum_y_nxt = sum_y_r + SUM_W'(rd_y);
        if (j_r == LAST_IDX) begin
          j_nxt     = '0;
          s_nxt     = '0;
          dsum_nxt  = '0;
          state_nxt = cspm_pkg::ST_OFS;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end

      cspm_pkg::ST_OFS: begin
        nx_nxt    = off_x;
        ny_nxt    = off_y;
        state_nxt = cspm_pkg::ST_DIFF;
      end

      cspm_pkg::ST_DIFF: begin
        dx_nxt    = dxw[OFF_W] ? OFF_W'(-dxw) : OFF_W'(dxw);
        dy_nxt    = dyw[OFF_W] ? OFF_W'(-dyw) : OFF_W'(dyw);
        state_nxt = cspm_pkg::ST_SQX;
      end

      cspm_pkg::ST_SQX: begin
        sq_nxt    = SQ_W'(prod);
        state_nxt = cspm_pkg::ST_SQY;
      end

      cspm_pkg::ST_SQY: begin
        sq_nxt    = sq_r + SQ_W'(prod);
        state_nxt = cspm_pkg::ST_RSTART;
      end

      cspm_pkg::ST_RSTART: begin
        sq_start  = 1'b1;
        state_nxt = cspm_pkg::ST_RWAIT;
      end

      cspm_pkg::ST_RWAIT: begin
        if (sq_done) begin
          if (j_r == LAST_IDX) begin
            // full diagonal summed, keep the strictly smaller one
            if ((s_r == '0) || (dsum_tot < best_sum_r)) begin
              best_nxt     = s_r;
              best_sum_nxt = dsum_tot;
            end
            dsum_nxt = '0;
            j_nxt    = '0;
            if (s_r == LAST_IDX) begin
              state_nxt = cspm_pkg::ST_EMIT_LOAD;
            end else begin
              s_nxt     = s_r + IDX_W'(1);
              state_nxt = cspm_pkg::ST_OFS;
            end
          end else begin
            dsum_nxt  = dsum_tot;
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = cspm_pkg::ST_OFS;
          end
        end
      end

      cspm_pkg::ST_EMIT_LOAD: begin
        // compares are done, so the new offset replaces the old one here
        prev_we       = 1'b1;
        out_valid_nxt = 1'b1;
        out_label_nxt = LW'(lbl_idx);
        out_x_nxt     = rd_x;
        out_y_nxt     = rd_y;
        out_shift_nxt = LW'(best_r);
        out_last_nxt  = (j_r == LAST_IDX);
        state_nxt     = cspm_pkg::ST_EMIT_WAIT;
      end

      cspm_pkg::ST_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (j_r == LAST_IDX) begin
            cnt_nxt   = '0;
            j_nxt     = '0;
            state_nxt = cspm_pkg::ST_LOAD;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = cspm_pkg::ST_EMIT_LOAD;
          end
        end
      end

      default: begin
        state_nxt = cspm_pkg::ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cspm_pkg::ST_LOAD;
      cnt_r       <= '0;
      j_r         <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    best_sum_r  <= best_sum_nxt;
    dsum_r      <= dsum_nxt;
    sum_x_r     <= sum_x_nxt;
    sum_y_r     <= sum_y_nxt;
    nx_r        <= nx_nxt;
    ny_r        <= ny_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    sq_r        <= sq_nxt;
    out_label_r <= out_label_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_shift_r <= out_shift_nxt;
    out_last_r  <= out_last_nxt;
  end

  // corner store written at the fill count
  always_ff @(posedge clk) begin
    if (corner_we) begin
      corner_x_r[cnt_r[IDX_W-1:0]] <= in_corner_x;
      corner_y_r[cnt_r[IDX_W-1:0]] <= in_corner_y;
    end
  end

  // previous offsets start at zero, so the first frame picks shift zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POINTS; i++) begin
        prev_x_r[i] <= '0;
        prev_y_r[i] <= '0;
      end
    end else if (prev_we) begin
      prev_x_r[j_r] <= off_x;
      prev_y_r[j_r] <= off_y;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_label  = out_label_r;
  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_chosen_shift = out_shift_r;
  assign out_last_point   = out_last_r;

  // no corner is taken while a result is on offer
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(POINTS))
    else $error("corner count overflow");

  // the root unit is only waited on after being started
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cspm_pkg::ST_RWAIT) |-> (sq_busy || sq_done))
    else $error("waiting on idle root unit");

  // the frame's final transfer reopens the input
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_point) |=> (in_ready && (cnt_r == '0)))
    else $error("input not reopened after frame");

endmodule
